### src/prq_pkg.sv
// Shared codes and field widths for the priority ready queue.
// No dependencies; used by priority_ready_queue.
package prq_pkg;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned PRI_W    = 32;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 6;
	localparam int unsigned ENTRY_W  = KEY_W + PRI_W;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_RUNNABLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL         = 2'd3;

endpackage

### src/priority_ready_queue.sv
// Ready queue of thread keys, highest priority first, FIFO among equals.
// Uses prq_pkg for field widths, request modes and status codes.
//
// Entries sit in one memory, head at address 0, one read and one write port,
// with registered read data. A sequencer walks that memory one entry per cycle:
// insert walks from the tail toward the head, moving each lower-priority entry
// one place down, and drops the new key in behind the first entry of equal or
// higher priority; pop and remove walk from the head, find the entry and slide
// every later entry up one place. A full queue, an empty queue or an unknown
// mode skips the walk and goes straight to the result. The port does not take
// a new beat until the previous walk has finished, and a result waits in the
// output register until taken.
module priority_ready_queue #(
	parameter int unsigned QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: mode[1:0], thread_key[33:2], priority_req[65:34], zero[71:66]
	input  logic [71:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: status[1:0], out_key[33:2], out_priority[65:34], occupancy[71:66]
	output logic [71:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS0,
		S_DRP,
		S_RES
	} state_t;

	state_t state_q;

	// Entry store: {priority, key}
	logic [prq_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [prq_pkg::ENTRY_W-1:0] rd_q;

	logic [CW-1:0]                 cnt_q;
	logic [AW-1:0]                 idx_q;
	logic                          found_q;
	logic                          is_pop_q;
	logic [prq_pkg::KEY_W-1:0]     req_key_q;
	logic [prq_pkg::PRI_W-1:0]     req_pri_q;
	logic [prq_pkg::STATUS_W-1:0]  res_status_q;
	logic [prq_pkg::KEY_W-1:0]     res_key_q;
	logic [prq_pkg::PRI_W-1:0]     res_pri_q;
	logic [71:0]                   m_tdata_q;
	logic                          m_tvalid_q;

	logic [prq_pkg::MODE_W-1:0]  in_mode;
	logic [prq_pkg::KEY_W-1:0]   in_key;
	logic [prq_pkg::PRI_W-1:0]   in_pri;
	logic                        s_accept;
	logic [prq_pkg::KEY_W-1:0]   ent_key;
	logic [prq_pkg::PRI_W-1:0]   ent_pri;
	logic                        ins_move;
	logic                        idx_last;
	logic                        drp_hit;
	logic [AW-1:0]               rd_addr;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [prq_pkg::ENTRY_W-1:0] wr_data;

	assign in_mode  = s_tdata[1:0];
	assign in_key   = s_tdata[33:2];
	assign in_pri   = s_tdata[65:34];
	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tdata  = m_tdata_q;
	assign m_tvalid = m_tvalid_q;

	assign ent_key  = rd_q[prq_pkg::KEY_W-1:0];
	assign ent_pri  = rd_q[prq_pkg::ENTRY_W-1:prq_pkg::KEY_W];
	assign ins_move = $signed(req_pri_q) > $signed(ent_pri);
	assign idx_last = (CW'(idx_q) == cnt_q - 1'b1);
	assign drp_hit  = !found_q && (is_pop_q ? !ent_pri[prq_pkg::PRI_W-1]
	                                        : (ent_key == req_key_q));

	// Pick read and write addresses for the walk
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {req_pri_q, req_key_q};
		case (state_q)
			S_IDLE: begin
				if (in_mode == prq_pkg::MODE_INSERT) begin
					rd_addr = AW'(cnt_q - 1'b1);
				end
				// insert into an empty queue writes straight to the head
				wr_en   = s_accept && (in_mode == prq_pkg::MODE_INSERT) && (cnt_q == '0);
				wr_data = {in_pri, in_key};
			end
			S_INS: begin
				rd_addr = idx_q - 1'b1;
				wr_en   = 1'b1;
				wr_addr = idx_q + 1'b1;
				if (ins_move) begin
					wr_data = rd_q;
				end
			end
			S_INS0: begin
				wr_en = 1'b1;
			end
			S_DRP: begin
				rd_addr = idx_q + 1'b1;
				wr_en   = found_q;
				wr_addr = idx_q - 1'b1;
				wr_data = rd_q;
			end
			default: begin
			end
		endcase
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			is_pop_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
			req_key_q    <= '0;
			req_pri_q    <= '0;
			res_status_q <= prq_pkg::ST_DONE;
			res_key_q    <= '0;
			res_pri_q    <= '0;
			m_tdata_q    <= '0;
		end else begin
			// drop the result once taken, unless a new one loads now
			if (m_tvalid_q && m_tready && (state_q != S_RES)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						req_key_q    <= in_key;
						req_pri_q    <= in_pri;
						found_q      <= 1'b0;
						is_pop_q     <= (in_mode == prq_pkg::MODE_POP);
						res_status_q <= prq_pkg::ST_DONE;
						res_key_q    <= '0;
						res_pri_q    <= '0;
						idx_q        <= '0;
						state_q      <= S_RES;
						case (in_mode)
							prq_pkg::MODE_INSERT: begin
								if (cnt_q >= CW'(QUEUE_DEPTH)) begin
									res_status_q <= prq_pkg::ST_FULL;
								end else if (cnt_q == '0) begin
									cnt_q <= cnt_q + 1'b1;
								end else begin
									idx_q   <= AW'(cnt_q - 1'b1);
									state_q <= S_INS;
								end
							end
							prq_pkg::MODE_POP: begin
								if (cnt_q == '0) begin
									res_status_q <= prq_pkg::ST_NOT_RUNNABLE;
								end else begin
									state_q <= S_DRP;
								end
							end
							prq_pkg::MODE_REMOVE: begin
								if (cnt_q == '0) begin
									res_status_q <= prq_pkg::ST_NOT_FOUND;
								end else begin
									state_q <= S_DRP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS: begin
					// move one entry down, or drop the new key in behind it
					if (!ins_move) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RES;
					end else if (idx_q == '0) begin
						state_q <= S_INS0;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_INS0: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_RES;
				end
				S_DRP: begin
					if (!found_q && is_pop_q && ent_pri[prq_pkg::PRI_W-1]) begin
						// head not runnable: leave the queue alone
						res_status_q <= prq_pkg::ST_NOT_RUNNABLE;
						state_q      <= S_RES;
					end else begin
						if (drp_hit) begin
							found_q <= 1'b1;
							if (is_pop_q) begin
								res_key_q <= ent_key;
								res_pri_q <= ent_pri;
							end
						end
						if (idx_last) begin
							if (found_q || drp_hit) begin
								cnt_q <= cnt_q - 1'b1;
							end else begin
								res_status_q <= prq_pkg::ST_NOT_FOUND;
							end
							state_q <= S_RES;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_RES: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {prq_pkg::OCC_W'(cnt_q), res_pri_q, res_key_q,
						               res_status_q};
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### dv/tb.sv
// Self-checking bench for priority_ready_queue: a directed table, then random
// traffic with idle gaps on the request side and stalls on the result side.
// Depends on prq_pkg and priority_ready_queue.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 32;
	// Mode value with no operation behind it
	localparam logic [prq_pkg::MODE_W-1:0] MODE_NOOP = 2'd3;
	localparam int unsigned PHASES = 16;
	localparam int unsigned PHASE_ITEMS = 100;

	typedef struct packed {
		logic [prq_pkg::MODE_W-1:0] mode;
		logic [prq_pkg::KEY_W-1:0]  key;
		logic [prq_pkg::PRI_W-1:0]  pri;
	} request_t;

	typedef struct packed {
		logic [prq_pkg::STATUS_W-1:0] status;
		logic [prq_pkg::KEY_W-1:0]    key;
		logic [prq_pkg::PRI_W-1:0]    pri;
		logic [prq_pkg::OCC_W-1:0]    occ;
	} result_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		result_t  res;
	} dir_row_t;

	// Directed rows; typed rows carry the result read straight off the behavior
	localparam dir_row_t DIRECTED_ROWS [18] = '{
		// pop and remove on an empty queue, no-op mode
		'{'{prq_pkg::MODE_POP,    32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_NOT_RUNNABLE, 32'h0, 32'h0, 6'd0}},
		'{'{prq_pkg::MODE_REMOVE, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_NOT_FOUND, 32'h0, 32'h0, 6'd0}},
		'{'{MODE_NOOP,            32'hFFFF_FFFF, 32'h8000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd0}},
		// extremes of key and priority, then equal priorities in arrival order
		'{'{prq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd1}},
		'{'{prq_pkg::MODE_INSERT, 32'h0000_0000, 32'h8000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd2}},
		'{'{prq_pkg::MODE_INSERT, 32'h1234_5678, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd3}},
		'{'{prq_pkg::MODE_INSERT, 32'hA5A5_A5A5, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd4}},
		// duplicate key at a lower priority
		'{'{prq_pkg::MODE_INSERT, 32'h1234_5678, 32'hFFFF_FFFF}, 1'b0, '0},
		'{'{prq_pkg::MODE_POP,    32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'd4}},
		'{'{prq_pkg::MODE_POP,    32'hDEAD_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h1234_5678, 32'h0000_0000, 6'd3}},
		// remove takes the remaining copy of the duplicate
		'{'{prq_pkg::MODE_REMOVE, 32'h1234_5678, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd2}},
		'{'{prq_pkg::MODE_REMOVE, 32'hDEAD_BEEF, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_NOT_FOUND, 32'h0, 32'h0, 6'd2}},
		'{'{prq_pkg::MODE_POP,    32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'hA5A5_A5A5, 32'h0000_0000, 6'd1}},
		// head has a negative priority
		'{'{prq_pkg::MODE_POP,    32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_NOT_RUNNABLE, 32'h0, 32'h0, 6'd1}},
		'{'{MODE_NOOP,            32'h5A5A_5A5A, 32'h7FFF_FFFF}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd1}},
		'{'{prq_pkg::MODE_INSERT, 32'h0000_0001, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd2}},
		'{'{prq_pkg::MODE_REMOVE, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0, 32'h0, 6'd1}},
		'{'{prq_pkg::MODE_POP,    32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{prq_pkg::ST_DONE, 32'h0000_0001, 32'h0000_0000, 6'd0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [71:0] s_tdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;

	// Mirror of the queue contents, head at index 0
	logic [prq_pkg::KEY_W-1:0]        model_keys [DEPTH];
	logic signed [prq_pkg::PRI_W-1:0] model_pris [DEPTH];
	int unsigned                      model_count = 0;

	result_t     pending_results [$];
	int unsigned mismatch_count = 0;
	int unsigned stall_pct = 0;

	priority_ready_queue #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one request to the mirror and return the result it must give
	function automatic result_t apply_request(input request_t req);
		result_t     res;
		int unsigned pos;
		res = '0;
		res.status = prq_pkg::ST_DONE;
		case (req.mode)
			prq_pkg::MODE_INSERT: begin
				if (model_count >= DEPTH) begin
					res.status = prq_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < model_count && $signed(req.pri) <= model_pris[pos])
						pos++;
					for (int unsigned i = model_count; i > pos; i--) begin
						model_keys[i] = model_keys[i-1];
						model_pris[i] = model_pris[i-1];
					end
					model_keys[pos] = req.key;
					model_pris[pos] = req.pri;
					model_count++;
				end
			end
			prq_pkg::MODE_POP: begin
				if (model_count == 0 || model_pris[0] < 0) begin
					res.status = prq_pkg::ST_NOT_RUNNABLE;
				end else begin
					res.key = model_keys[0];
					res.pri = model_pris[0];
					pos = 0;
				end
			end
			prq_pkg::MODE_REMOVE: begin
				res.status = prq_pkg::ST_NOT_FOUND;
				for (int unsigned i = 0; i < model_count; i++) begin
					if (res.status == prq_pkg::ST_NOT_FOUND &&
							model_keys[i] == req.key) begin
						res.status = prq_pkg::ST_DONE;
						pos = i;
					end
				end
			end
			default: ;
		endcase
		// close the gap left by a successful pop or remove
		if (res.status == prq_pkg::ST_DONE &&
				(req.mode == prq_pkg::MODE_POP || req.mode == prq_pkg::MODE_REMOVE)) begin
			for (int unsigned i = pos; i + 1 < model_count; i++) begin
				model_keys[i] = model_keys[i+1];
				model_pris[i] = model_pris[i+1];
			end
			model_count--;
		end
		res.occ = model_count[prq_pkg::OCC_W-1:0];
		return res;
	endfunction

	// Idle length: mostly short, now and then long
	function automatic int unsigned gap_length();
		if ($urandom_range(99) < 80)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	function automatic logic [prq_pkg::PRI_W-1:0] random_priority();
		int unsigned roll;
		logic [prq_pkg::PRI_W-1:0] pri;
		roll = $urandom_range(99);
		if (roll < 30) begin
			pri = 32'($signed($urandom_range(5)) - 1);
		end else if (roll < 40) begin
			case ($urandom_range(3))
				0: pri = 32'h7FFF_FFFF;
				1: pri = 32'h8000_0000;
				2: pri = 32'hFFFF_FFFF;
				default: pri = 32'h0000_0000;
			endcase
		end else begin
			pri = $urandom;
			if ($urandom_range(99) < 70)
				pri[prq_pkg::PRI_W-1] = 1'b0;
		end
		return pri;
	endfunction

	// Draw a request; the mix of operations follows the kind of phase
	function automatic request_t random_request(input int unsigned kind);
		request_t    req;
		int unsigned roll;
		int unsigned ins_pct;
		int unsigned pop_pct;
		case (kind)
			0, 3: begin ins_pct = 75; pop_pct = 10; end
			1: begin ins_pct = 20; pop_pct = 55; end
			default: begin ins_pct = 40; pop_pct = 30; end
		endcase
		roll = $urandom_range(99);
		req.key = $urandom;
		if ($urandom_range(99) < 30)
			req.key[prq_pkg::KEY_W-1:3] = '0;
		req.pri = random_priority();
		if (roll < ins_pct) begin
			req.mode = prq_pkg::MODE_INSERT;
		end else if (roll < ins_pct + pop_pct) begin
			req.mode = prq_pkg::MODE_POP;
		end else if (roll < 97) begin
			req.mode = prq_pkg::MODE_REMOVE;
			if (model_count > 0 && $urandom_range(99) < 70)
				req.key = model_keys[$urandom_range(model_count - 1)];
		end else begin
			req.mode = MODE_NOOP;
		end
		return req;
	endfunction

	// Hold one beat until accepted, then queue the result it must give
	task automatic send_request(input request_t req, input logic typed, input result_t typed_res);
		result_t predicted;
		s_tdata <= {6'd0, req.pri, req.key, req.mode};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(req);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic maybe_idle(input int unsigned pct);
		if ($urandom_range(99) < pct) begin
			s_tvalid <= 1'b0;
			repeat (gap_length()) @(posedge clk);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Reset: held low from the start, released once
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stimulus
	initial begin
		request_t    req;
		int unsigned gap_pct;
		while (!arst_n) @(posedge clk);
		repeat (2) @(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
			maybe_idle(30);
		end

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			// vary pressure: some phases run back to back on both sides
			case ($urandom_range(2))
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 20; stall_pct = 10; end
				default: begin gap_pct = 50; stall_pct = 40; end
			endcase
			for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
				req = random_request(ph % 4);
				send_request(req, 1'b0, '0);
				maybe_idle(gap_pct);
			end
		end
		s_tvalid <= 1'b0;

		// drain, then watch a while for stray beats
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("priority_ready_queue: match");
		end else begin
			$display("priority_ready_queue: mismatch");
		end
		$finish;
	end

	// Result side: check each beat, stall at random
	initial begin
		int unsigned stall_left;
		result_t     want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no request waiting: 0x%0h", m_tdata);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
					compare_field("out_key", want.key, m_tdata[33:2]);
					compare_field("out_priority", want.pri, m_tdata[65:34]);
					compare_field("occupancy", 32'(want.occ), 32'(m_tdata[71:66]));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (arst_n && $urandom_range(99) < stall_pct) begin
				stall_left = gap_length() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("priority_ready_queue: mismatch");
		$finish;
	end

endmodule

### filelist.f
src/prq_pkg.sv
src/priority_ready_queue.sv
dv/tb.sv
